@@ src/stlfo_pkg.sv @@
`timescale 1ns / 1ps

package stlfo_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int TANH_TABLE_ENTRIES = 256;

    localparam int QUARTER_LEN  = SINE_TABLE_ENTRIES / 4;
    localparam int QUARTER_BITS = $clog2(QUARTER_LEN);
    localparam int TANH_BITS    = $clog2(TANH_TABLE_ENTRIES);

    localparam int DRIVE_W   = 21;
    localparam int LUT_X_W   = 36;
    localparam int IDX_W     = LUT_X_W - 34 + TANH_BITS;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 21;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIVN_W    = 31;
    localparam int DIVD_W    = 15;
    localparam int DIVQ_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [15:0] SMALL_Q16 = 16'd66;
    localparam logic [14:0] Q15_MAX   = 15'h7fff;

    localparam logic [15:0] RST_DEPTH  = 16'd0;
    localparam logic [15:0] RST_SMOOTH = 16'd136;
    localparam logic [3:0]  RST_SYNC   = 4'd0;
    localparam logic [31:0] RST_FREE   = 32'd44739;
    localparam logic [31:0] RST_BEAT   = 32'd178957;
    localparam logic [15:0] RST_SHAPE  = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH    = 3'd0,
        REG_SMOOTH   = 3'd1,
        REG_SYNC     = 3'd2,
        REG_FREE_INC = 3'd3,
        REG_BEAT_INC = 3'd4,
        REG_SHAPE    = 3'd5
    } cfg_index_t;

    localparam logic [3:0] SYNC_QUARTER = 4'd1;
    localparam logic [3:0] SYNC_HALF    = 4'd2;
    localparam logic [3:0] SYNC_ONE     = 4'd3;
    localparam logic [3:0] SYNC_TWO     = 4'd4;
    localparam logic [3:0] SYNC_THREE   = 4'd5;
    localparam logic [3:0] SYNC_FOUR    = 4'd6;
    localparam logic [3:0] SYNC_SIX     = 4'd7;
    localparam logic [3:0] SYNC_EIGHT   = 4'd8;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
    } sample_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_out;
        logic [SAMPLE_BITS-1:0] right_out;
    } result_t;

    typedef struct packed {
        logic [15:0] depth;
        logic [15:0] smoothing_coefficient;
        logic [3:0]  sync_mode;
        logic [31:0] free_increment;
        logic [31:0] beat_increment;
        logic [15:0] shape_amount;
    } cfg_t;

    typedef struct packed {
        logic    bypass;
        sample_t samples;
    } queue_item_t;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } div_req_t;

    typedef logic [15:0] sine_tab_t [0:QUARTER_LEN];
    typedef logic [15:0] tanh_tab_t [0:TANH_TABLE_ENTRIES];

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // shift-subtract quotient, used only while building the tables
    function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
        longint unsigned q, r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        longint unsigned x, x2, term, sum, r, n;
        for (int i = 0; i <= QUARTER_LEN; i++)
        begin
            x = (HALF_PI_Q30 * longint'(i)) >> QUARTER_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (n = 1; n <= 8; n++)
            begin
                term = udiv((term * x2) >> 30, (2 * n) * (2 * n + 1));
                if (n[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            r = (sum + 64'd16384) >> 15;
            tab[i] = (r > 64'd32767) ? 16'd32767 : r[15:0];
        end
        return tab;
    endfunction

    function automatic tanh_tab_t build_tanh_tab();
        tanh_tab_t tab;
        longint unsigned z, e, term, den, t, n;
        for (int i = 0; i <= TANH_TABLE_ENTRIES; i++)
        begin
            z = (longint'(i) << 30) >> TANH_BITS;
            term = Q30_ONE;
            e = Q30_ONE;
            for (n = 1; n <= 16; n++)
            begin
                term = udiv((term * z) >> 30, n);
                if (n[0])
                    e = e - term;
                else
                    e = e + term;
            end
            for (int k = 0; k < 4; k++)
                e = (e * e + 64'd536870912) >> 30;
            den = Q30_ONE + e;
            t = udiv((Q30_ONE - e) * 64'd32768 + (den >> 1), den);
            tab[i] = (t > 64'd32767) ? 16'd32767 : t[15:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();
    localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

@@ src/stlfo_front.sv @@
`timescale 1ns / 1ps

module stlfo_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           depth,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  stlfo_pkg::sample_t    sample,
    output logic                  q_valid,
    output stlfo_pkg::queue_item_t q_item,
    input  logic                  q_pop
);

    stlfo_pkg::queue_item_t slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign sample_ready = (count_reg != 2'd2);
    assign push         = sample_valid && sample_ready;
    assign q_valid      = (count_reg != 2'd0);
    assign q_item       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    // small depth: the request passes untouched and leaves the state alone
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].bypass  <= (depth < stlfo_pkg::SMALL_Q16);
            slot_reg[wr_ptr_reg].samples <= sample;
        end
    end

endmodule

@@ src/stlfo_div.sv @@
`timescale 1ns / 1ps

module stlfo_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stlfo_pkg::div_req_t           req,
    output logic                          done,
    output logic [stlfo_pkg::DIVQ_W-1:0]  quotient
);

    logic [stlfo_pkg::DIVD_W-1:0] rem_reg;
    logic [stlfo_pkg::DIVD_W-1:0] den_reg;
    logic [15:0]                  low_reg;
    logic [stlfo_pkg::DIVQ_W-1:0] quo_reg;
    logic [3:0]                   count_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [stlfo_pkg::DIVD_W:0]   trial;
    logic                         qbit;
    logic [stlfo_pkg::DIVD_W:0]   diff;

    assign trial    = {rem_reg, low_reg[15]};
    assign qbit     = (trial >= {1'b0, den_reg});
    assign diff     = trial - {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= 4'd0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 4'd1;
                if (count_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[stlfo_pkg::DIVN_W-1:16];
            low_reg <= req.dividend[15:0];
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[stlfo_pkg::DIVD_W-1:0] : trial[stlfo_pkg::DIVD_W-1:0];
            low_reg <= {low_reg[14:0], 1'b0};
            quo_reg <= {quo_reg[stlfo_pkg::DIVQ_W-2:0], qbit};
        end
    end

endmodule

@@ src/stlfo_back.sv @@
`timescale 1ns / 1ps

module stlfo_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  stlfo_pkg::cfg_t        cfg,
    input  logic                   q_valid,
    input  stlfo_pkg::queue_item_t q_item,
    output logic                   q_pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output stlfo_pkg::result_t     result
);

    localparam int SB = stlfo_pkg::SAMPLE_BITS;
    localparam int QB = stlfo_pkg::QUARTER_BITS;
    localparam int TB = stlfo_pkg::TANH_BITS;
    localparam int IDX_W_L = stlfo_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SMOOTH, S_SINE, S_TD0, S_TD1, S_TN0, S_TN1, S_DIV,
        S_GAIN, S_G2, S_ML, S_MR, S_FIN, S_OUT
    } state_t;

    state_t                           state_reg;
    logic [31:0]                      phase_reg;
    logic [31:0]                      sd_reg;
    logic                             sd_up_reg;
    logic [SB-1:0]                    left_reg;
    logic [SB-1:0]                    right_reg;
    logic [SB-1:0]                    left_res_reg;
    logic [SB-1:0]                    right_res_reg;
    logic [stlfo_pkg::PROD_W-1:0]     prod_reg;
    logic [14:0]                      mag_reg;
    logic                             neg_reg;
    logic [15:0]                      lut_a_reg;
    logic                             lut_sat_reg;
    logic [14:0]                      den_reg;
    logic                             num_ge_reg;
    logic [16:0]                      gain_reg;
    logic                             out_valid_reg;
    stlfo_pkg::result_t               out_reg;

    logic [stlfo_pkg::MUL_A_W-1:0]    mul_a;
    logic [stlfo_pkg::MUL_B_W-1:0]    mul_b;
    logic [31:0]                      target;
    logic                             sd_up;
    logic [31:0]                      sd_diff;
    logic [stlfo_pkg::DRIVE_W-1:0]    drive;
    logic [QB:0]                      sine_idx;
    logic [stlfo_pkg::LUT_X_W-1:0]    lut_x;
    logic [IDX_W_L-1:0]               idx_full;
    logic                             lut_sat;
    logic [TB:0]                      idx_a;
    logic [TB:0]                      idx_b;
    logic [15:0]                      tab_a;
    logic [15:0]                      tab_b;
    logic [15:0]                      tab_d;
    logic [15:0]                      lut_frac;
    logic [32:0]                      lut_round;
    logic [16:0]                      lut_sum;
    logic [14:0]                      tanh_val;
    logic [14:0]                      den_next;
    logic [16:0]                      half;
    logic [16:0]                      gain_next;
    logic [stlfo_pkg::PROD_W-1:0]     prod_rnd;
    logic [SB:0]                      scaled;
    logic [SB-1:0]                    left_abs;
    logic [SB-1:0]                    right_abs;
    logic [37:0]                      beat_scaled;
    logic [31:0]                      inc;
    stlfo_pkg::div_req_t              div_req;
    logic                             div_done;
    logic [stlfo_pkg::DIVQ_W-1:0]     div_q;

    function automatic logic [SB-1:0] sat_sign(input logic [SB:0] r, input logic neg);
        logic [SB:0] nr;
        nr = ~r + (SB+1)'(1);
        if (neg)
            return nr[SB-1:0];
        else if (r >= (SB+1)'(1) << (SB-1))
            return {1'b0, {(SB-1){1'b1}}};
        else
            return r[SB-1:0];
    endfunction

    assign target   = {cfg.depth, 16'd0};
    assign sd_up    = (target >= sd_reg);
    assign sd_diff  = sd_up ? target - sd_reg : sd_reg - target;
    assign drive    = stlfo_pkg::DRIVE_W'(17'h10000)
                    + stlfo_pkg::DRIVE_W'(cfg.shape_amount) * stlfo_pkg::DRIVE_W'(19);
    assign sine_idx = phase_reg[30] ? (QB+1)'(stlfo_pkg::QUARTER_LEN) - {1'b0, phase_reg[29 -: QB]}
                                    : {1'b0, phase_reg[29 -: QB]};

    // tanh lookup argument: Q.31, drive << 15 for the divisor, mag * drive for the dividend
    assign lut_x    = (state_reg == S_TN0) ? prod_reg[stlfo_pkg::LUT_X_W-1:0]
                                           : {drive, 15'd0};
    assign idx_full = lut_x[stlfo_pkg::LUT_X_W-1 -: IDX_W_L];
    assign lut_sat  = (idx_full >= IDX_W_L'(stlfo_pkg::TANH_TABLE_ENTRIES));
    assign idx_a    = {1'b0, idx_full[TB-1:0]};
    assign idx_b    = idx_a + (TB+1)'(1);
    assign tab_a    = stlfo_pkg::TANH_TAB[idx_a];
    assign tab_b    = stlfo_pkg::TANH_TAB[idx_b];
    assign tab_d    = (tab_b >= tab_a) ? tab_b - tab_a : 16'd0;
    assign lut_frac = lut_x[33-TB -: 16];
    assign lut_round = (33'(prod_reg[31:0]) + 33'd32768) >> 16;
    assign lut_sum  = 17'(lut_a_reg) + lut_round[16:0];
    assign tanh_val = lut_sat_reg ? stlfo_pkg::Q15_MAX : lut_sum[14:0];
    assign den_next = (tanh_val == 15'd0) ? 15'd1 : tanh_val;

    assign half     = neg_reg ? 17'h08000 + 17'(mag_reg) : 17'h08000 - 17'(mag_reg);
    assign prod_rnd = prod_reg + stlfo_pkg::PROD_W'(32768);
    assign gain_next = 17'h10000 - 17'(prod_rnd[stlfo_pkg::PROD_W-1:16]);
    assign scaled   = prod_rnd[16 +: SB+1];
    assign left_abs  = left_reg[SB-1] ? -left_reg : left_reg;
    assign right_abs = right_reg[SB-1] ? -right_reg : right_reg;

    always_comb
    begin
        unique case (cfg.sync_mode)
            stlfo_pkg::SYNC_QUARTER: beat_scaled = 38'(cfg.beat_increment);
            stlfo_pkg::SYNC_HALF:    beat_scaled = 38'(cfg.beat_increment) << 1;
            stlfo_pkg::SYNC_ONE:     beat_scaled = 38'(cfg.beat_increment) << 2;
            stlfo_pkg::SYNC_TWO:     beat_scaled = 38'(cfg.beat_increment) << 3;
            stlfo_pkg::SYNC_THREE:   beat_scaled = (38'(cfg.beat_increment) << 3)
                                                 + (38'(cfg.beat_increment) << 2);
            stlfo_pkg::SYNC_FOUR:    beat_scaled = 38'(cfg.beat_increment) << 4;
            stlfo_pkg::SYNC_SIX:     beat_scaled = (38'(cfg.beat_increment) << 4)
                                                 + (38'(cfg.beat_increment) << 3);
            stlfo_pkg::SYNC_EIGHT:   beat_scaled = 38'(cfg.beat_increment) << 5;
            default:                 beat_scaled = 38'd0;
        endcase
    end

    assign inc = (cfg.sync_mode >= stlfo_pkg::SYNC_QUARTER && cfg.sync_mode <= stlfo_pkg::SYNC_EIGHT)
               ? beat_scaled[33:2] : cfg.free_increment;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SMOOTH:
            begin
                mul_a = sd_diff;
                mul_b = stlfo_pkg::MUL_B_W'(cfg.smoothing_coefficient);
            end
            S_TD0, S_TN0:
            begin
                mul_a = stlfo_pkg::MUL_A_W'(tab_d);
                mul_b = stlfo_pkg::MUL_B_W'(lut_frac);
            end
            S_TD1:
            begin
                mul_a = stlfo_pkg::MUL_A_W'(mag_reg);
                mul_b = drive;
            end
            S_GAIN:
            begin
                mul_a = stlfo_pkg::MUL_A_W'(sd_reg[31:16]);
                mul_b = stlfo_pkg::MUL_B_W'(half);
            end
            S_ML:
            begin
                mul_a = stlfo_pkg::MUL_A_W'(left_abs);
                mul_b = stlfo_pkg::MUL_B_W'(gain_reg);
            end
            S_MR:
            begin
                mul_a = stlfo_pkg::MUL_A_W'(right_abs);
                mul_b = stlfo_pkg::MUL_B_W'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_req.start    = (state_reg == S_TN1);
    assign div_req.dividend = {tanh_val, 16'd0} >> 1 | stlfo_pkg::DIVN_W'(den_reg[14:1]);
    assign div_req.divisor  = den_reg;

    stlfo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 32'd0;
            sd_reg        <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && (!out_valid_reg || result_ready))
                out_valid_reg <= 1'b1;
            else if (result_valid && result_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (q_valid)
                        state_reg <= q_item.bypass ? S_OUT : S_SMOOTH;
                S_SMOOTH:
                    state_reg <= S_SINE;
                S_SINE:
                begin
                    sd_reg <= sd_up_reg ? sd_reg + prod_reg[47:16] : sd_reg - prod_reg[47:16];
                    state_reg <= (cfg.shape_amount >= stlfo_pkg::SMALL_Q16) ? S_TD0 : S_GAIN;
                end
                S_TD0:   state_reg <= S_TD1;
                S_TD1:   state_reg <= S_TN0;
                S_TN0:   state_reg <= S_TN1;
                S_TN1:   state_reg <= S_DIV;
                S_DIV:
                    if (div_done)
                        state_reg <= S_GAIN;
                S_GAIN:  state_reg <= S_G2;
                S_G2:    state_reg <= S_ML;
                S_ML:    state_reg <= S_MR;
                S_MR:    state_reg <= S_FIN;
                S_FIN:
                begin
                    phase_reg <= phase_reg + inc;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (!out_valid_reg || result_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= stlfo_pkg::PROD_W'(mul_a) * stlfo_pkg::PROD_W'(mul_b);
        unique case (state_reg)
            S_IDLE:
                if (q_valid)
                begin
                    left_reg      <= q_item.samples.left_sample;
                    right_reg     <= q_item.samples.right_sample;
                    left_res_reg  <= q_item.samples.left_sample;
                    right_res_reg <= q_item.samples.right_sample;
                end
            S_SMOOTH:
                sd_up_reg <= sd_up;
            S_SINE:
            begin
                mag_reg <= stlfo_pkg::SINE_TAB[sine_idx][14:0];
                neg_reg <= phase_reg[31];
            end
            S_TD0, S_TN0:
            begin
                lut_a_reg   <= tab_a;
                lut_sat_reg <= lut_sat;
            end
            S_TD1:
                den_reg <= den_next;
            S_TN1:
                num_ge_reg <= (tanh_val >= den_reg);
            S_DIV:
                if (div_done)
                    mag_reg <= (num_ge_reg || div_q[15]) ? stlfo_pkg::Q15_MAX : div_q[14:0];
            S_G2:
                gain_reg <= gain_next;
            S_MR:
                left_res_reg <= sat_sign(scaled, left_reg[SB-1]);
            S_FIN:
                right_res_reg <= sat_sign(scaled, right_reg[SB-1]);
            S_OUT:
                if (!out_valid_reg || result_ready)
                begin
                    out_reg.left_out  <= left_res_reg;
                    out_reg.right_out <= right_res_reg;
                end
            default:
            begin
            end
        endcase
    end

endmodule

@@ src/stereo_tremolo_shaped_lfo_unit.sv @@
`timescale 1ns / 1ps

// Stereo tremolo: each request (a left/right sample pair) returns the pair scaled by
// one gain, 1 - depth * (1 - lfo) / 2, from a quarter-wave sine LFO, optionally
// squared up through a normalized tanh curve. A two-entry request queue feeds a
// sequencer built around one shared 32x21 multiplier. With shape_amount at 66 or
// more the tanh path runs, and the 16-step divider that normalizes the tanh curve
// dominates the work per pair. When depth is below 66 the pair passes through
// unchanged and the LFO state holds. The user must write registers through
// cfg_write/cfg_index/cfg_data only while no request is in flight; the block
// itself does not enforce this.
module stereo_tremolo_shaped_lfo_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  stlfo_pkg::sample_t                  sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output stlfo_pkg::result_t                  result,
    input  logic                                cfg_write,
    input  logic [stlfo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stlfo_pkg::CFG_DAT_W-1:0]     cfg_data
);

    stlfo_pkg::cfg_t        cfg_reg;
    logic                   q_valid;
    logic                   q_pop;
    stlfo_pkg::queue_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth                 <= stlfo_pkg::RST_DEPTH;
            cfg_reg.smoothing_coefficient <= stlfo_pkg::RST_SMOOTH;
            cfg_reg.sync_mode             <= stlfo_pkg::RST_SYNC;
            cfg_reg.free_increment        <= stlfo_pkg::RST_FREE;
            cfg_reg.beat_increment        <= stlfo_pkg::RST_BEAT;
            cfg_reg.shape_amount          <= stlfo_pkg::RST_SHAPE;
        end
        else if (cfg_write)
        begin
            unique case (stlfo_pkg::cfg_index_t'(cfg_index))
                stlfo_pkg::REG_DEPTH:    cfg_reg.depth                 <= cfg_data[15:0];
                stlfo_pkg::REG_SMOOTH:   cfg_reg.smoothing_coefficient <= cfg_data[15:0];
                stlfo_pkg::REG_SYNC:     cfg_reg.sync_mode             <= cfg_data[3:0];
                stlfo_pkg::REG_FREE_INC: cfg_reg.free_increment        <= cfg_data;
                stlfo_pkg::REG_BEAT_INC: cfg_reg.beat_increment        <= cfg_data;
                stlfo_pkg::REG_SHAPE:    cfg_reg.shape_amount          <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    stlfo_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .depth        (cfg_reg.depth),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    stlfo_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

@@ src/stlfo_checker.sv @@
`timescale 1ns / 1ps

module stlfo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_ready,
    input stlfo_pkg::sample_t sample,
    input logic               result_valid,
    input logic               result_ready,
    input stlfo_pkg::result_t result
);

    logic [2:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else
            pending_reg <= pending_reg + 3'(sample_valid && sample_ready)
                         - 3'(result_valid && result_ready);
    end

    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(sample))
        else $error("request dropped or changed while stalled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result dropped or changed while stalled");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> $past(sample_valid && sample_ready) || $past(!sample_ready))
        else $error("sample_ready fell without a new request");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result without an outstanding request");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more requests in flight than the block holds");

endmodule

bind stereo_tremolo_shaped_lfo_unit stlfo_checker u_stlfo_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import stlfo_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_STALL = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    sample_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    stereo_tremolo_shaped_lfo_unit dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // tremolo state mirror
    logic [15:0] m_depth = RST_DEPTH;
    logic [15:0] m_smooth = RST_SMOOTH;
    logic [3:0]  m_sync = RST_SYNC;
    logic [31:0] m_free = RST_FREE;
    logic [31:0] m_beat = RST_BEAT;
    logic [15:0] m_shape = RST_SHAPE;
    logic [31:0] m_phase = '0;
    logic [31:0] m_smoothed = '0;

    sample_t pending_pairs[$];
    result_t expected_pairs[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stalls_served = 0;
    int stall_left = 0;

    function automatic longint unsigned tanh_of(longint unsigned x);
        longint unsigned p, idx, frac, a, b, d;
        p = x * TANH_TABLE_ENTRIES;
        idx = p >> 34;
        frac = (p >> 18) & 64'hffff;
        if (idx >= TANH_TABLE_ENTRIES)
            return Q15_MAX;
        a = TANH_TAB[idx];
        b = TANH_TAB[idx + 1];
        d = (b >= a) ? b - a : 0;
        return a + ((d * frac + 32768) >> 16);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] scale_sample(logic [SAMPLE_BITS-1:0] raw,
                                                            longint unsigned gain);
        longint s, r, hi, lo;
        longint unsigned mag;
        s = longint'(signed'(raw));
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        mag = (s < 0) ? -s : s;
        r = longint'((mag * gain + 32768) >> 16);
        if (s < 0)
            r = -r;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic result_t tremolo_step(sample_t s);
        result_t r;
        logic [31:0] target;
        logic [1:0] quad;
        longint unsigned k, mag, drive, den, num, q, d16, half, gain, mult;
        longint lfo;
        if (m_depth < SMALL_Q16)
        begin
            r.left_out = s.left_sample;
            r.right_out = s.right_sample;
            return r;
        end
        target = {m_depth, 16'd0};
        if (target >= m_smoothed)
            m_smoothed = m_smoothed + 32'((64'(m_smooth) * (target - m_smoothed)) >> 16);
        else
            m_smoothed = m_smoothed - 32'((64'(m_smooth) * (m_smoothed - target)) >> 16);
        quad = m_phase[31:30];
        k = (64'(m_phase[29:0]) * QUARTER_LEN) >> 30;
        mag = quad[0] ? SINE_TAB[QUARTER_LEN - k] : SINE_TAB[k];
        if (m_shape >= SMALL_Q16)
        begin
            drive = 65536 + 64'(m_shape) * 19;
            den = tanh_of(drive << 15);
            num = tanh_of(mag * drive);
            if (den == 0)
                den = 1;
            q = (num * 32768 + den / 2) / den;
            mag = (q > Q15_MAX) ? Q15_MAX : q;
        end
        lfo = quad[1] ? -longint'(mag) : longint'(mag);
        half = 32768 - lfo;
        d16 = m_smoothed >> 16;
        gain = 65536 - ((d16 * half + 32768) >> 16);
        r.left_out = scale_sample(s.left_sample, gain);
        r.right_out = scale_sample(s.right_sample, gain);
        case (m_sync)
            SYNC_QUARTER: mult = 1;
            SYNC_HALF:    mult = 2;
            SYNC_ONE:     mult = 4;
            SYNC_TWO:     mult = 8;
            SYNC_THREE:   mult = 12;
            SYNC_FOUR:    mult = 16;
            SYNC_SIX:     mult = 24;
            SYNC_EIGHT:   mult = 32;
            default:      mult = 0;
        endcase
        if (mult == 0)
            m_phase = m_phase + m_free;
        else
            m_phase = m_phase + 32'((64'(m_beat) * mult) >> 2);
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            expected_pairs.push_back(tremolo_step(sample));
        if (!sample_valid || sample_ready)
        begin
            if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample <= pending_pairs.pop_front();
                sample_valid <= 1'b1;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        if (result_valid && result_ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                $error("unexpected result %h", result);
                mismatches++;
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (result.left_out !== want.left_out)
                begin
                    $error("left_out expected %h actual %h", want.left_out, result.left_out);
                    mismatches++;
                end
                if (result.right_out !== want.right_out)
                begin
                    $error("right_out expected %h actual %h", want.right_out, result.right_out);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (stalls_served < stall_requests)
        begin
            stalls_served <= stalls_served + 1;
            stall_left <= LONG_STALL;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic drain();
        while (pending_pairs.size() > 0 || sample_valid || expected_pairs.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_DEPTH:    m_depth = v[15:0];
            REG_SMOOTH:   m_smooth = v[15:0];
            REG_SYNC:     m_sync = v[3:0];
            REG_FREE_INC: m_free = v;
            REG_BEAT_INC: m_beat = v;
            REG_SHAPE:    m_shape = v[15:0];
            default:      ;
        endcase
    endtask

    task automatic setup(logic [15:0] dp, logic [15:0] sm, logic [3:0] sy,
                         logic [31:0] fr, logic [31:0] bt, logic [15:0] sh);
        drain();
        write_reg(REG_DEPTH, {16'd0, dp});
        write_reg(REG_SMOOTH, {16'd0, sm});
        write_reg(REG_SYNC, {28'd0, sy});
        write_reg(REG_FREE_INC, fr);
        write_reg(REG_BEAT_INC, bt);
        write_reg(REG_SHAPE, {16'd0, sh});
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: return SAMPLE_BITS'($urandom_range(0, 8)) - SAMPLE_BITS'(4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_q16();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd65;
            2: return 16'd66;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_inc();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_pair(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r);
        sample_t s;
        s.left_sample = l;
        s.right_sample = r;
        pending_pairs.push_back(s);
    endtask

    initial
    begin
        logic [15:0] dp;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 49;

        queue_pair(24'h7fffff, 24'h800000);
        queue_pair(24'h000000, 24'hffffff);
        queue_pair(24'h555555, 24'haaaaaa);
        queue_pair(24'h000001, 24'h7ffffe);
        setup(16'hffff, 16'hffff, SYNC_EIGHT, 32'd44739, 32'hffffffff, 16'd0);
        queue_pair(24'h7fffff, 24'h800000);
        queue_pair(24'h800001, 24'h000001);
        repeat (4) queue_pair(pick_sample(), pick_sample());
        setup(16'hffff, 16'd0, 4'd9, 32'h40000000, 32'd178957, 16'hffff);
        repeat (6) queue_pair(pick_sample(), pick_sample());
        setup(16'd66, 16'hffff, 4'd15, 32'h12345678, 32'd1, 16'd66);
        repeat (4) queue_pair(24'h7fffff, 24'h800000);
        setup(16'd65, 16'd1, SYNC_QUARTER, 32'hffffffff, 32'd3, 16'd65);
        repeat (4) queue_pair(pick_sample(), pick_sample());

        for (int ph = 0; ph < 12; ph++)
        begin
            dp = ($urandom_range(0, 5) == 0) ? pick_q16() : 16'($urandom_range(66, 65535));
            setup(dp, pick_q16(), 4'($urandom_range(0, 15)), pick_inc(), pick_inc(), pick_q16());
            if (ph == 4)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 20;
            end
            if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (65) queue_pair(pick_sample(), pick_sample());
            if (ph == 2 || ph == 9)
                stall_requests++;
        end
        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
